// ===== design/multichannel_relay_cycle_timer_defines.svh =====
// Assertion helpers shared by the relay timer RTL.
`ifndef MULTICHANNEL_RELAY_CYCLE_TIMER_DEFINES_SVH
`define MULTICHANNEL_RELAY_CYCLE_TIMER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MRCT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MRCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mrct_pkg.sv =====
`timescale 1ns / 1ps
package mrct_pkg;

   localparam int CHANNEL_COUNT = 4;
   localparam int REPORTED      = 4;
   localparam int MAX_MINUTES   = 20;
   localparam int MIN_W         = 5;
   localparam int TICK_W        = 16;
   localparam int SEL_W         = 3;
   localparam logic [TICK_W-1:0] TPM_RESET = 16'd60000;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_SET   = 2'd1,
      MODE_STOP  = 2'd2,
      MODE_START = 2'd3
   } mode_type;

   // Controls common to every channel for one accepted word
   typedef struct packed {
      logic              tick;
      logic              restart;
      logic              stop;
      logic [TICK_W-1:0] tpm;
      logic [MIN_W-1:0]  off_min;
      logic [MIN_W-1:0]  on_min;
      logic              start_on;
   } chan_ctl_type;

   // Status of the word that goes into the result
   typedef struct packed {
      logic err;
      logic frozen;
   } cmd_status_type;

endpackage

// ===== design/mrct_channel.sv =====
`timescale 1ns / 1ps
module mrct_channel (
   input  logic                       clock,
   input  logic                       reset,
   input  mrct_pkg::chan_ctl_type     ctl,
   input  logic                       set_sel,
   output logic                       relay_in,
   output logic [mrct_pkg::MIN_W-1:0] remaining_in
);
   import mrct_pkg::*;

   logic [MIN_W-1:0]  off_ff, off_in;
   logic [MIN_W-1:0]  on_ff, on_in;
   logic              relay_ff;
   logic [MIN_W-1:0]  min_ff, min_in;
   logic [TICK_W-1:0] sub_ff, sub_in;
   logic              relay_set;
   logic [MIN_W-1:0]  phase_len;
   logic [MIN_W-1:0]  next_len;
   logic              minute_done;

   // Take new settings, or drop the off time on stop
   always_comb begin
      off_in    = set_sel ? ctl.off_min : (ctl.stop ? '0 : off_ff);
      on_in     = set_sel ? ctl.on_min : on_ff;
      relay_set = set_sel ? ctl.start_on : relay_ff;
      phase_len = relay_set ? on_in : off_in;
   end

   assign minute_done = ({1'b0, sub_ff} + 17'd1) >= {1'b0, ctl.tpm};

   // Advance the countdown, toggle on expiry, reload on restart
   always_comb begin
      relay_in = relay_set;
      min_in   = min_ff;
      sub_in   = sub_ff;
      if (ctl.restart) begin
         min_in = phase_len;
         sub_in = '0;
      end else if (ctl.tick && phase_len != '0) begin
         if (min_ff == '0 && sub_ff == '0) begin
            relay_in = ~relay_set;
            min_in   = relay_set ? off_in : on_in;
            sub_in   = '0;
         end else if (minute_done) begin
            sub_in = '0;
            if (min_ff != '0) begin
               min_in = min_ff - MIN_W'(1);
            end
         end else begin
            sub_in = sub_ff + TICK_W'(1);
         end
      end
   end

   // Report minutes left in the phase after this word
   always_comb begin
      next_len = relay_in ? on_in : off_in;
      if (next_len == '0) begin
         remaining_in = '0;
      end else if (sub_in == '0) begin
         remaining_in = min_in + MIN_W'(1);
      end else begin
         remaining_in = min_in;
      end
   end

   // Hold channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff   <= '0;
         on_ff    <= '0;
         relay_ff <= 1'b0;
         min_ff   <= '0;
         sub_ff   <= '0;
      end else begin
         off_ff   <= off_in;
         on_ff    <= on_in;
         relay_ff <= relay_in;
         min_ff   <= min_in;
         sub_ff   <= sub_in;
      end
   end

endmodule

// ===== design/mrct_decode.sv =====
`timescale 1ns / 1ps
module mrct_decode (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  mrct_pkg::mode_type                  mode,
   input  logic [mrct_pkg::SEL_W-1:0]          valve_select,
   input  logic [mrct_pkg::MIN_W-1:0]          off_minutes_in,
   input  logic [mrct_pkg::MIN_W-1:0]          on_minutes_in,
   input  logic                                start_on,
   input  logic [mrct_pkg::TICK_W-1:0]         ticks_per_minute,
   output mrct_pkg::chan_ctl_type              ctl,
   output logic [mrct_pkg::CHANNEL_COUNT-1:0]  set_sel,
   output mrct_pkg::cmd_status_type            status,
   output logic                                frozen
);
   import mrct_pkg::*;

   logic frozen_ff, frozen_in;
   logic set_ok;
   logic is_tick, is_set, is_stop, is_start;

   assign set_ok = (32'(valve_select) < CHANNEL_COUNT)
                && (32'(off_minutes_in) <= MAX_MINUTES)
                && (32'(on_minutes_in) <= MAX_MINUTES);

   // Decode the command kind
   always_comb begin
      is_tick  = 1'b0;
      is_set   = 1'b0;
      is_stop  = 1'b0;
      is_start = 1'b0;
      unique case (mode)
         MODE_TICK:  is_tick  = 1'b1;
         MODE_SET:   is_set   = 1'b1;
         MODE_STOP:  is_stop  = 1'b1;
         MODE_START: is_start = 1'b1;
         default:    is_tick  = 1'b0;
      endcase
   end

   // Build channel controls
   always_comb begin
      ctl.tick     = accept && is_tick && !frozen_ff;
      ctl.restart  = accept && ((is_set && set_ok) || is_start);
      ctl.stop     = accept && is_stop;
      ctl.tpm      = (ticks_per_minute == '0) ? TICK_W'(1) : ticks_per_minute;
      ctl.off_min  = off_minutes_in;
      ctl.on_min   = on_minutes_in;
      ctl.start_on = start_on;
   end

   for (genvar i = 0; i < CHANNEL_COUNT; i++) begin : g_sel
      assign set_sel[i] = accept && is_set && set_ok && (32'(valve_select) == i);
   end

   // Freeze on stop, release on start
   always_comb begin
      frozen_in = frozen_ff;
      if (accept && is_stop) begin
         frozen_in = 1'b1;
      end else if (accept && is_start) begin
         frozen_in = 1'b0;
      end
   end

   assign status.err    = is_set && !set_ok;
   assign status.frozen = frozen_in;
   assign frozen        = frozen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frozen_ff <= 1'b0;
      end else begin
         frozen_ff <= frozen_in;
      end
   end

endmodule

// ===== design/multichannel_relay_cycle_timer.sv =====
`timescale 1ns / 1ps
// Four-channel cyclic relay timer. Every word on the req side is a command
// (tuser = mode: tick, set, stop, start) and yields exactly one rsp word with
// the relay bits, each channel's minutes left, an error flag and the stop
// flag. All channel counters update in parallel in one combinational pass from
// the channel registers into the result register, so while req_tready is high
// one word is taken every clock and its result appears in the cycle after. The
// result register is the only buffer; req_tready drops only while a result waits
// unread. Write ticks_per_minute via csr_wr_en/csr_wr_data only while idle; not enforced.
module multichannel_relay_cycle_timer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] valve_select, [7:3] off_minutes_in, [12:8] on_minutes_in,
   // [13] start_on, [15:14] zero
   input  logic [15:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] relay_states, [8:4] remaining_ch0, [13:9] remaining_ch1,
   // [18:14] remaining_ch2, [23:19] remaining_ch3, [24] command_error,
   // [25] stopped, [31:26] zero
   output logic [31:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import mrct_pkg::*;
   `include "multichannel_relay_cycle_timer_defines.svh"

   logic [TICK_W-1:0]          tpm_ff;
   logic                       accept;
   chan_ctl_type               ctl;
   logic [CHANNEL_COUNT-1:0]   set_sel;
   cmd_status_type             status;
   logic                       frozen;
   logic [CHANNEL_COUNT-1:0]   relay_in;
   logic [MIN_W-1:0]           remaining_in [CHANNEL_COUNT];
   logic [REPORTED-1:0]        relay_rep;
   logic [REPORTED*MIN_W-1:0]  remaining_rep;
   logic                       rsp_valid_ff;
   logic [31:0]                rsp_data_ff, rsp_data_in;

   // Hold the minute length register
   always_ff @(posedge clock) begin
      if (reset) begin
         tpm_ff <= TPM_RESET;
      end else if (csr_wr_en) begin
         tpm_ff <= csr_wr_data;
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   mrct_decode u_decode (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .mode             (mode_type'(req_tuser)),
      .valve_select     (req_tdata[2:0]),
      .off_minutes_in   (req_tdata[7:3]),
      .on_minutes_in    (req_tdata[12:8]),
      .start_on         (req_tdata[13]),
      .ticks_per_minute (tpm_ff),
      .ctl              (ctl),
      .set_sel          (set_sel),
      .status           (status),
      .frozen           (frozen)
   );

   for (genvar i = 0; i < CHANNEL_COUNT; i++) begin : g_chan
      mrct_channel u_channel (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .set_sel      (set_sel[i]),
         .relay_in     (relay_in[i]),
         .remaining_in (remaining_in[i])
      );
   end

   // Gather the reported channels; missing ones read as zero
   for (genvar r = 0; r < REPORTED; r++) begin : g_rep
      if (r < CHANNEL_COUNT) begin : g_have
         assign relay_rep[r] = relay_in[r];
         assign remaining_rep[r*MIN_W +: MIN_W] = remaining_in[r];
      end else begin : g_none
         assign relay_rep[r] = 1'b0;
         assign remaining_rep[r*MIN_W +: MIN_W] = '0;
      end
   end

   assign rsp_data_in = {6'd0, status.frozen, status.err, remaining_rep, relay_rep};

   // Load the result register on accept, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `MRCT_ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, rsp_valid_ff,
      "accepted word produced no result")
   `MRCT_ASSERT_NEXT(a_frozen_tick_holds, clock, reset,
      accept && req_tuser == MODE_TICK && frozen, rsp_data_ff[25],
      "tick while frozen released the freeze")
   `MRCT_ASSERT_NEXT(a_stop_reports_stopped, clock, reset,
      accept && req_tuser == MODE_STOP, rsp_data_ff[25],
      "stop word did not report stopped")
   `MRCT_ASSERT_SAME(a_error_only_on_set, clock, reset, accept && status.err,
      req_tuser == MODE_SET, "error flagged on a non-set word")

endmodule
